/* rtl/rtcwdt_pkg.sv */
// ----------------------------------------------------------------------------
// rtcwdt_pkg
// shared types, constants and controller commands for the rtc watchdog block
// ----------------------------------------------------------------------------
package rtcwdt_pkg;

    localparam int unsigned DefStoreCount   = 8;
    localparam int unsigned DefWdtStages    = 4;
    localparam int unsigned DefTimeHighBits = 16;

    localparam logic [29:0] CPU_HZ_DEFAULT  = 30'd160000000;
    localparam logic [29:0] SRC0_HZ_RESET   = 30'd150000;
    localparam logic [29:0] SRC1_HZ_RESET   = 30'd32768;
    localparam logic [29:0] SRC2_HZ_RESET   = 30'd8500000;
    localparam logic [4:0]  MULT_RESET      = 5'd1;
    localparam logic [31:0] KEY_RESET       = 32'd1356348065;
    localparam logic [2:0]  ACTION_MASK     = 3'h7;
    localparam int unsigned WDT_INT_BIT     = 3;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CPU_HZ = 3'd0,
        CFG_SRC0   = 3'd1,
        CFG_SRC1   = 3'd2,
        CFG_SRC2   = 3'd3,
        CFG_MULT   = 3'd4,
        CFG_KEY    = 3'd5
    } cfg_idx_t;

    // item opcodes
    typedef enum logic [2:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_ADV   = 3'd2,
        OP_SET   = 3'd3,
        OP_CLR   = 3'd4
    } op_t;

    // register map
    localparam logic [4:0] R_TIME_UPD  = 5'd0;
    localparam logic [4:0] R_TIME_LO   = 5'd1;
    localparam logic [4:0] R_TIME_HI   = 5'd2;
    localparam logic [4:0] R_CLK_CONF  = 5'd3;
    localparam logic [4:0] R_INT_ENA   = 5'd4;
    localparam logic [4:0] R_INT_RAW   = 5'd5;
    localparam logic [4:0] R_INT_ST    = 5'd6;
    localparam logic [4:0] R_INT_CLR   = 5'd7;
    localparam logic [4:0] R_WDT_CONF0 = 5'd8;
    localparam logic [4:0] R_WDT_HOLD3 = 5'd12;
    localparam logic [4:0] R_WDT_FEED  = 5'd13;
    localparam logic [4:0] R_WDT_PROT  = 5'd14;
    localparam logic [4:0] R_STORE0    = 5'd16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV1,
        ST_MUL,
        ST_DIV2,
        ST_COUNT,
        ST_WDT,
        ST_ACCESS,
        ST_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture input item
        logic prep;     // pick divisor and source, fraction reset on divisor change
        logic div_start;// start a division
        logic div_sel;  // 0 first division, 1 second
        logic mul;      // form quotient * slow and remainder * slow + fraction
        logic count;    // add ticks to counter
        logic wdt_step; // one stage walk step
        logic access;   // register access
        logic out_load; // fill result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic zero_cycles;
        logic div_done;
        logic wdt_done;
    } ctrl_sts_t;

endpackage

/* rtl/rtcwdt_div.sv */
// ----------------------------------------------------------------------------
// rtcwdt_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rtcwdt_div
    import rtcwdt_pkg::*;
#(
    parameter int unsigned NW = 62,
    parameter int unsigned DW = 30
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);
    localparam int unsigned CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW:0]   trial;

    assign trial = {r_reg[DW-1:0], q_reg[NW-1]};

    // shift and subtract
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                r_next = trial - {1'b0, den};
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done = !busy_reg && !start;
    assign quo  = q_reg;
    assign rem  = r_reg[DW-1:0];
endmodule

/* rtl/rtcwdt_ctrl.sv */
// ----------------------------------------------------------------------------
// rtcwdt_ctrl
// sequencer for one item: scale, count, watchdog walk, access, result
// ----------------------------------------------------------------------------
module rtcwdt_ctrl
    import rtcwdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic       out_free,
    input  ctrl_sts_t  sts,
    output logic       in_ready,
    output ctrl_cmd_t  cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (sts.zero_cycles)
                begin
                    state_next = ST_ACCESS;
                end
                else
                begin
                    cmd.prep      = 1'b1;
                    state_next    = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                if (sts.div_done)
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_COUNT;
            end
            ST_COUNT:
            begin
                if (sts.div_done)
                begin
                    cmd.count  = 1'b1;
                    state_next = ST_WDT;
                end
            end
            ST_WDT:
            begin
                if (sts.wdt_done)
                begin
                    state_next = ST_ACCESS;
                end
                else
                begin
                    cmd.wdt_step = 1'b1;
                end
            end
            ST_ACCESS:
            begin
                cmd.access = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

/* rtl/rtcwdt_dp.sv */
// ----------------------------------------------------------------------------
// rtcwdt_dp
// registers, tick scaling, counter, watchdog stages and interrupt lines
// ----------------------------------------------------------------------------
module rtcwdt_dp
    import rtcwdt_pkg::*;
#(
    parameter int unsigned SCRATCH_WORDS  = DefStoreCount,
    parameter int unsigned WDT_STAGES     = DefWdtStages,
    parameter int unsigned TIME_HIGH_BITS = DefTimeHighBits
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    output ctrl_sts_t   sts,
    input  logic [2:0]  in_opcode,
    input  logic [4:0]  in_reg_index,
    input  logic [31:0] in_write_data,
    input  logic [31:0] in_elapsed_cycles,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [31:0] cfg_wdata,
    output logic [31:0] res_read_data,
    output logic        res_irq,
    output logic [1:0]  res_kind,
    output logic [2:0]  res_stage
);
    localparam int unsigned TW = 32 + TIME_HIGH_BITS;
    localparam int unsigned SW = (SCRATCH_WORDS > 1) ? $clog2(SCRATCH_WORDS) : 1;

    // configuration
    logic [29:0] cpu_hz_reg, src0_reg, src1_reg, src2_reg;
    logic [4:0]  mult_reg;
    logic [31:0] key_reg;

    // item
    logic [2:0]  op_reg;
    logic [4:0]  idx_reg;
    logic [31:0] wd_reg;
    logic [31:0] cyc_reg;

    // state
    logic [TW-1:0] rtc_reg, latch_reg;
    logic [29:0]   frac_reg, denom_reg;
    logic [1:0]    clk_sel_reg;
    logic [31:0]   int_ena_reg, int_raw_reg, prot_reg;
    logic [31:0]   wconf_reg [WDT_STAGES+1];
    logic [35:0]   sticks_reg;
    logic [2:0]    stage_reg;
    logic [31:0]   store_reg [SCRATCH_WORDS];

    // scaling working registers
    logic [29:0] cpu_w_reg, slow_w_reg;
    logic [61:0] ticks_reg;
    logic [61:0] frac_prod_reg;
    logic [1:0]  kind_reg;

    // division unit
    logic [61:0] div_num, div_quo;
    logic [29:0] div_rem;
    logic        div_done;

    assign div_num = cmd.div_sel ? frac_prod_reg : {30'd0, cyc_reg};

    rtcwdt_div #(.NW(62), .DW(30)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (cpu_w_reg),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // slow source select with fallback to source zero
    logic [29:0] slow_sel;
    always_comb
    begin
        case (clk_sel_reg)
            2'd1:    slow_sel = src1_reg;
            2'd2:    slow_sel = src2_reg;
            default: slow_sel = src0_reg;
        endcase
        if (slow_sel == '0)
        begin
            slow_sel = src0_reg;
        end
    end

    logic [29:0] cpu_eff;
    assign cpu_eff = (cpu_hz_reg != '0) ? cpu_hz_reg : CPU_HZ_DEFAULT;

    // watchdog helpers
    logic        wdt_active;
    logic [35:0] hold, left;
    logic [4:0]  mult_eff;
    logic [31:0] hold_raw;
    logic [2:0]  action;
    logic [4:0]  act_sh;

    assign wdt_active = (stage_reg < 3'(WDT_STAGES)) &&
                        ((wconf_reg[0][31] | wconf_reg[0][10]) != 1'b0);

    always_comb
    begin
        hold_raw = 32'd0;
        for (int s = 0; s < WDT_STAGES; s++)
        begin
            if (stage_reg == 3'(s))
            begin
                hold_raw = wconf_reg[s+1];
            end
        end
        if (mult_reg == 5'd0)
        begin
            mult_eff = 5'd1;
        end
        else if (mult_reg > 5'd16)
        begin
            mult_eff = 5'd16;
        end
        else
        begin
            mult_eff = mult_reg;
        end
        if (stage_reg == 3'd0)
        begin
            hold = 36'(hold_raw) * 36'(mult_eff);
        end
        else
        begin
            hold = 36'(hold_raw);
        end
        if (hold == '0)
        begin
            hold = 36'd1;
        end
        left   = (sticks_reg < hold) ? hold - sticks_reg : 36'd1;
        act_sh = 5'd28 - 5'(3 * stage_reg);
        action = 3'(wconf_reg[0] >> act_sh) & ACTION_MASK;
    end

    assign sts.zero_cycles = (cyc_reg == '0);
    assign sts.div_done    = div_done;
    assign sts.wdt_done    = (ticks_reg == '0) || !wdt_active;

    // access decode
    logic        unlocked;
    logic [31:0] rd_val;
    logic [4:0]  sidx;
    assign unlocked = (prot_reg == key_reg);
    assign sidx     = idx_reg - R_STORE0;

    always_comb
    begin
        rd_val = 32'd0;
        if (idx_reg >= R_STORE0)
        begin
            if (32'(sidx) < SCRATCH_WORDS)
            begin
                rd_val = store_reg[sidx[SW-1:0]];
            end
        end
        else if (idx_reg >= R_WDT_CONF0 && idx_reg <= R_WDT_HOLD3)
        begin
            for (int i = 0; i <= WDT_STAGES; i++)
            begin
                if (idx_reg == R_WDT_CONF0 + 5'(i))
                begin
                    rd_val = wconf_reg[i];
                end
            end
        end
        else
        begin
            unique case (idx_reg)
                R_TIME_LO:  rd_val = latch_reg[31:0];
                R_TIME_HI:  rd_val = 32'(latch_reg[TW-1:32]);
                R_CLK_CONF: rd_val = {30'd0, clk_sel_reg};
                R_INT_ENA:  rd_val = int_ena_reg;
                R_INT_RAW:  rd_val = int_raw_reg;
                R_INT_ST:   rd_val = int_raw_reg & int_ena_reg;
                R_WDT_PROT: rd_val = prot_reg;
                default:    rd_val = 32'd0;
            endcase
        end
    end

    // arming check for wdt_conf[0] writes
    logic prev_armed, now_active, conf0_hit;
    assign conf0_hit  = (idx_reg == R_WDT_CONF0);
    assign prev_armed = wdt_active;
    assign now_active = (stage_reg < 3'(WDT_STAGES)) &&
                        ((conf0_hit ? (wd_reg[31] | wd_reg[10])
                                    : (wconf_reg[0][31] | wconf_reg[0][10])) != 1'b0);

    // interrupt lines and enables as they stand after the access
    logic [31:0] raw_after, ena_after;
    always_comb
    begin
        raw_after = int_raw_reg;
        ena_after = int_ena_reg;
        if (op_reg == OP_SET)
        begin
            raw_after = int_raw_reg | wd_reg;
        end
        else if (op_reg == OP_CLR)
        begin
            raw_after = int_raw_reg & ~wd_reg;
        end
        else if (op_reg == OP_WRITE && idx_reg == R_INT_CLR)
        begin
            raw_after = int_raw_reg & ~wd_reg;
        end
        if (op_reg == OP_WRITE && idx_reg == R_INT_ENA)
        begin
            ena_after = wd_reg;
        end
    end

    logic [31:0] rd_hold_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_hz_reg  <= CPU_HZ_DEFAULT;
            src0_reg    <= SRC0_HZ_RESET;
            src1_reg    <= SRC1_HZ_RESET;
            src2_reg    <= SRC2_HZ_RESET;
            mult_reg    <= MULT_RESET;
            key_reg     <= KEY_RESET;
            rtc_reg     <= '0;
            latch_reg   <= '0;
            frac_reg    <= '0;
            denom_reg   <= '0;
            clk_sel_reg <= '0;
            int_ena_reg <= '0;
            int_raw_reg <= '0;
            prot_reg    <= KEY_RESET;
            sticks_reg  <= '0;
            stage_reg   <= '0;
            kind_reg    <= '0;
            res_irq     <= 1'b0;
            for (int i = 0; i <= WDT_STAGES; i++)
            begin
                wconf_reg[i] <= '0;
            end
            for (int i = 0; i < SCRATCH_WORDS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_CPU_HZ: cpu_hz_reg <= cfg_wdata[29:0];
                    CFG_SRC0:   src0_reg   <= cfg_wdata[29:0];
                    CFG_SRC1:   src1_reg   <= cfg_wdata[29:0];
                    CFG_SRC2:   src2_reg   <= cfg_wdata[29:0];
                    CFG_MULT:   mult_reg   <= cfg_wdata[4:0];
                    CFG_KEY:    key_reg    <= cfg_wdata;
                    default:    ;
                endcase
            end
            if (cmd.load)
            begin
                kind_reg <= '0;
            end
            // divisor change clears the carried fraction
            if (cmd.prep && denom_reg != cpu_eff)
            begin
                denom_reg <= cpu_eff;
                frac_reg  <= '0;
            end
            if (cmd.count)
            begin
                rtc_reg  <= rtc_reg + TW'(ticks_reg + div_quo);
                frac_reg <= div_rem;
            end
            // one stage per step
            if (cmd.wdt_step)
            begin
                if (ticks_reg < 62'(left))
                begin
                    sticks_reg <= sticks_reg + 36'(ticks_reg);
                end
                else
                begin
                    sticks_reg <= '0;
                    if (action == 3'd1)
                    begin
                        int_raw_reg[WDT_INT_BIT] <= 1'b1;
                        stage_reg <= stage_reg + 3'd1;
                    end
                    else if (action >= 3'd2 && action <= 3'd4)
                    begin
                        stage_reg <= 3'(WDT_STAGES);
                        kind_reg  <= 2'(action - 3'd1);
                    end
                    else
                    begin
                        stage_reg <= stage_reg + 3'd1;
                    end
                end
            end
            if (cmd.access)
            begin
                res_irq <= (raw_after & ena_after) != '0;
                if (op_reg == OP_SET)
                begin
                    int_raw_reg <= int_raw_reg | wd_reg;
                end
                else if (op_reg == OP_CLR)
                begin
                    int_raw_reg <= int_raw_reg & ~wd_reg;
                end
                else if (op_reg == OP_WRITE)
                begin
                    if (idx_reg >= R_STORE0)
                    begin
                        if (32'(sidx) < SCRATCH_WORDS)
                        begin
                            store_reg[sidx[SW-1:0]] <= wd_reg;
                        end
                    end
                    else if (idx_reg >= R_WDT_CONF0 && idx_reg <= R_WDT_HOLD3)
                    begin
                        if (unlocked && 32'(idx_reg - R_WDT_CONF0) <= WDT_STAGES)
                        begin
                            for (int i = 0; i <= WDT_STAGES; i++)
                            begin
                                if (idx_reg == R_WDT_CONF0 + 5'(i))
                                begin
                                    wconf_reg[i] <= wd_reg;
                                end
                            end
                            if (!prev_armed && now_active)
                            begin
                                stage_reg  <= '0;
                                sticks_reg <= '0;
                            end
                        end
                    end
                    else
                    begin
                        unique case (idx_reg)
                            R_TIME_UPD:
                            begin
                                if (wd_reg[31])
                                begin
                                    latch_reg <= rtc_reg;
                                end
                            end
                            R_CLK_CONF:
                            begin
                                if (wd_reg[1:0] != clk_sel_reg)
                                begin
                                    denom_reg <= '0;
                                    frac_reg  <= '0;
                                end
                                clk_sel_reg <= wd_reg[1:0];
                            end
                            R_INT_ENA:
                            begin
                                int_ena_reg <= wd_reg;
                            end
                            R_INT_CLR:
                            begin
                                int_raw_reg <= int_raw_reg & ~wd_reg;
                            end
                            R_WDT_FEED:
                            begin
                                if (unlocked && wd_reg[31])
                                begin
                                    stage_reg  <= '0;
                                    sticks_reg <= '0;
                                end
                            end
                            R_WDT_PROT: prot_reg <= wd_reg;
                            default:    ;
                        endcase
                    end
                end
            end
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_opcode;
            idx_reg <= in_reg_index;
            wd_reg  <= in_write_data;
            cyc_reg <= in_elapsed_cycles;
            ticks_reg <= '0;
        end
        if (cmd.prep)
        begin
            cpu_w_reg  <= cpu_eff;
            slow_w_reg <= slow_sel;
        end
        // quotient * slow, remainder * slow + fraction
        if (cmd.mul)
        begin
            ticks_reg     <= 62'(div_quo[31:0]) * 62'(slow_w_reg);
            frac_prod_reg <= 62'(div_rem) * 62'(slow_w_reg) + 62'(frac_reg);
        end
        if (cmd.count)
        begin
            ticks_reg <= ticks_reg + div_quo;
        end
        if (cmd.wdt_step)
        begin
            if (ticks_reg < 62'(left))
            begin
                ticks_reg <= '0;
            end
            else if (action >= 3'd2 && action <= 3'd4)
            begin
                ticks_reg <= '0;
            end
            else
            begin
                ticks_reg <= ticks_reg - 62'(left);
            end
        end
        if (cmd.access)
        begin
            rd_hold_reg <= (op_reg == OP_READ) ? rd_val : 32'd0;
        end
    end

    assign res_read_data = rd_hold_reg;
    assign res_kind      = kind_reg;
    assign res_stage     = wdt_active ? stage_reg : 3'(WDT_STAGES);
endmodule

/* rtl/rtc_controller_with_staged_watchdog_unit.sv */
// ----------------------------------------------------------------------------
// rtc_controller_with_staged_watchdog_unit
// always-on rtc controller with key-protected multi-stage watchdog
// ----------------------------------------------------------------------------
// channel   | dir | handshake            | payload
// s_axis    | in  | s_tvalid / s_tready  | s_tdata: opcode, reg_index, write_data, elapsed
// m_axis    | out | m_tvalid / m_tready  | m_tdata: read_data, irq_level, reset_kind, stage
// cfg       | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one request at a time; an item with zero elapsed cycles skips scaling, counting and
// the watchdog walk, otherwise it makes two passes of the shared serial divider and
// up to four watchdog walk steps.
// reset clears the control state at once, no clearing pass; data registers are not reset.
// the result waits in the output register; the next request is taken while it waits.
module rtc_controller_with_staged_watchdog_unit
    import rtcwdt_pkg::*;
#(
    parameter int unsigned SCRATCH_WORDS  = DefStoreCount,
    parameter int unsigned WDT_STAGES     = DefWdtStages,
    parameter int unsigned TIME_HIGH_BITS = DefTimeHighBits
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // opcode[2:0], reg_index[7:3], write_data[39:8], elapsed[71:40]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // read_data[31:0], irq_level[32], reset_kind[34:33], stage[37:35]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    ctrl_cmd_t   cmd;
    ctrl_sts_t   sts;
    logic        in_fire;
    logic        mv_reg;
    logic [31:0] rd;
    logic        irq;
    logic [1:0]  kind;
    logic [2:0]  stg;
    logic [39:0] mdata_reg;

    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    rtcwdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (!mv_reg || m_tready),
        .sts      (sts),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    rtcwdt_dp #(
        .SCRATCH_WORDS  (SCRATCH_WORDS),
        .WDT_STAGES     (WDT_STAGES),
        .TIME_HIGH_BITS (TIME_HIGH_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .in_opcode         (s_tdata[2:0]),
        .in_reg_index      (s_tdata[7:3]),
        .in_write_data     (s_tdata[39:8]),
        .in_elapsed_cycles (s_tdata[71:40]),
        .cfg_we            (cfg_valid),
        .cfg_idx           (cfg_index),
        .cfg_wdata         (cfg_data),
        .res_read_data     (rd),
        .res_irq           (irq),
        .res_kind          (kind),
        .res_stage         (stg)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            mv_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            mdata_reg <= {2'b00, stg, kind, irq, rd};
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;

    // no request accepted while the sequencer is busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !s_tready)
        else $error("request accepted while busy");

    // result stage in range
    a_stage: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[37:35] <= 3'(WDT_STAGES))
        else $error("stage out of range");

    // a new result only lands in a free output register
    a_ovr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!mv_reg || m_tready))
        else $error("result overwritten");
endmodule
